// ===== design/sha_pkg.sv =====
`default_nettype none

package sha_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned ROUNDS      = 64;
  localparam int unsigned DIGEST_N    = 8;

  localparam int unsigned WCNT_W  = $clog2(BLOCK_WORDS);
  localparam int unsigned ROUND_W = $clog2(ROUNDS);

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [WCNT_W-1:0]  LAST_WORD  = WCNT_W'(BLOCK_WORDS - 1);
  localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);

  typedef logic [WORD_W-1:0] word_t;

  // One queued message word, tagged with whether it closes a block.
  typedef struct packed {
    word_t word;
    logic  last;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic     not_empty;
    logic     full;
    q_entry_t head;
  } q_status_t;

  typedef struct packed {
    logic loading;
    logic rounds_active;
    logic finishing;
  } back_status_t;

  typedef enum logic [2:0] {
    ST_LOAD   = 3'b001,
    ST_ROUND  = 3'b010,
    ST_FINISH = 3'b100
  } back_state_t;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (WORD_W - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t init_hash(input logic [2:0] idx);
    case (idx)
      3'd0:    init_hash = 32'h6a09e667;
      3'd1:    init_hash = 32'hbb67ae85;
      3'd2:    init_hash = 32'h3c6ef372;
      3'd3:    init_hash = 32'ha54ff53a;
      3'd4:    init_hash = 32'h510e527f;
      3'd5:    init_hash = 32'h9b05688c;
      3'd6:    init_hash = 32'h1f83d9ab;
      default: init_hash = 32'h5be0cd19;
    endcase
  endfunction

  function automatic word_t round_const(input logic [ROUND_W-1:0] idx);
    case (idx)
      6'd0:  round_const = 32'h428a2f98;
      6'd1:  round_const = 32'h71374491;
      6'd2:  round_const = 32'hb5c0fbcf;
      6'd3:  round_const = 32'he9b5dba5;
      6'd4:  round_const = 32'h3956c25b;
      6'd5:  round_const = 32'h59f111f1;
      6'd6:  round_const = 32'h923f82a4;
      6'd7:  round_const = 32'hab1c5ed5;
      6'd8:  round_const = 32'hd807aa98;
      6'd9:  round_const = 32'h12835b01;
      6'd10: round_const = 32'h243185be;
      6'd11: round_const = 32'h550c7dc3;
      6'd12: round_const = 32'h72be5d74;
      6'd13: round_const = 32'h80deb1fe;
      6'd14: round_const = 32'h9bdc06a7;
      6'd15: round_const = 32'hc19bf174;
      6'd16: round_const = 32'he49b69c1;
      6'd17: round_const = 32'hefbe4786;
      6'd18: round_const = 32'h0fc19dc6;
      6'd19: round_const = 32'h240ca1cc;
      6'd20: round_const = 32'h2de92c6f;
      6'd21: round_const = 32'h4a7484aa;
      6'd22: round_const = 32'h5cb0a9dc;
      6'd23: round_const = 32'h76f988da;
      6'd24: round_const = 32'h983e5152;
      6'd25: round_const = 32'ha831c66d;
      6'd26: round_const = 32'hb00327c8;
      6'd27: round_const = 32'hbf597fc7;
      6'd28: round_const = 32'hc6e00bf3;
      6'd29: round_const = 32'hd5a79147;
      6'd30: round_const = 32'h06ca6351;
      6'd31: round_const = 32'h14292967;
      6'd32: round_const = 32'h27b70a85;
      6'd33: round_const = 32'h2e1b2138;
      6'd34: round_const = 32'h4d2c6dfc;
      6'd35: round_const = 32'h53380d13;
      6'd36: round_const = 32'h650a7354;
      6'd37: round_const = 32'h766a0abb;
      6'd38: round_const = 32'h81c2c92e;
      6'd39: round_const = 32'h92722c85;
      6'd40: round_const = 32'ha2bfe8a1;
      6'd41: round_const = 32'ha81a664b;
      6'd42: round_const = 32'hc24b8b70;
      6'd43: round_const = 32'hc76c51a3;
      6'd44: round_const = 32'hd192e819;
      6'd45: round_const = 32'hd6990624;
      6'd46: round_const = 32'hf40e3585;
      6'd47: round_const = 32'h106aa070;
      6'd48: round_const = 32'h19a4c116;
      6'd49: round_const = 32'h1e376c08;
      6'd50: round_const = 32'h2748774c;
      6'd51: round_const = 32'h34b0bcb5;
      6'd52: round_const = 32'h391c0cb3;
      6'd53: round_const = 32'h4ed8aa4a;
      6'd54: round_const = 32'h5b9cca4f;
      6'd55: round_const = 32'h682e6ff3;
      6'd56: round_const = 32'h748f82ee;
      6'd57: round_const = 32'h78a5636f;
      6'd58: round_const = 32'h84c87814;
      6'd59: round_const = 32'h8cc70208;
      6'd60: round_const = 32'h90befffa;
      6'd61: round_const = 32'ha4506ceb;
      6'd62: round_const = 32'hbef9a3f7;
      default: round_const = 32'hc67178f2;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== design/sha_front.sv =====
`default_nettype none

module sha_front (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire logic [31:0]            in_message_word,
  input  wire sha_pkg::q_status_t     q_status,
  output logic                        in_stall,
  output sha_pkg::q_push_t            q_push
);

  // Position of the next word within its block.
  logic [sha_pkg::WCNT_W-1:0] wcnt_r;
  logic [sha_pkg::WCNT_W-1:0] wcnt_nxt;
  logic                       accept;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !q_status.full;

  always_comb begin
    q_push.valid      = accept;
    q_push.entry.word = in_message_word;
    q_push.entry.last = (wcnt_r == sha_pkg::LAST_WORD);
    wcnt_nxt          = accept ? wcnt_r + 1'b1 : wcnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcnt_r <= '0;
    end else begin
      wcnt_r <= wcnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/sha_queue.sv =====
`default_nettype none

module sha_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire sha_pkg::q_push_t    q_push,
  input  wire logic                q_pop,
  output sha_pkg::q_status_t       q_status
);

  sha_pkg::q_entry_t          mem_r [sha_pkg::QDEPTH];
  logic [sha_pkg::QPTR_W-1:0] wr_ptr_r;
  logic [sha_pkg::QPTR_W-1:0] wr_ptr_nxt;
  logic [sha_pkg::QPTR_W-1:0] rd_ptr_r;
  logic [sha_pkg::QPTR_W-1:0] rd_ptr_nxt;
  logic [sha_pkg::QCNT_W-1:0] cnt_r;
  logic [sha_pkg::QCNT_W-1:0] cnt_nxt;
  logic                       do_push;
  logic                       do_pop;

  always_comb begin
    q_status.not_empty = (cnt_r != '0);
    q_status.full      = (cnt_r == sha_pkg::QCNT_W'(sha_pkg::QDEPTH));
    q_status.head      = mem_r[rd_ptr_r];
    do_push            = q_push.valid && !q_status.full;
    do_pop             = q_pop && q_status.not_empty;
    wr_ptr_nxt         = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt         = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt            = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/sha_back.sv =====
`default_nettype none

module sha_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire sha_pkg::q_status_t   q_status,
  input  wire logic                 out_stall,
  output logic                      q_pop,
  output logic                      out_valid,
  output logic [7:0][31:0]          out_digest,
  output sha_pkg::back_status_t     status
);

  sha_pkg::back_state_t        state_r;
  sha_pkg::back_state_t        state_nxt;
  logic [sha_pkg::ROUND_W-1:0] round_r;
  logic [sha_pkg::ROUND_W-1:0] round_nxt;

  // Schedule window as a shift line: w_r[0] is the word of the current round.
  sha_pkg::word_t w_r   [sha_pkg::BLOCK_WORDS];
  sha_pkg::word_t w_nxt [sha_pkg::BLOCK_WORDS];
  // Working variables a..h.
  sha_pkg::word_t hv_r   [sha_pkg::DIGEST_N];
  sha_pkg::word_t hv_nxt [sha_pkg::DIGEST_N];

  logic [7:0][31:0] dig_r;
  logic [7:0][31:0] dig_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;

  sha_pkg::word_t t1;
  sha_pkg::word_t t2;
  sha_pkg::word_t ch;
  sha_pkg::word_t maj;
  sha_pkg::word_t w_new;
  logic           out_free;

  assign out_valid  = out_valid_r;
  assign out_digest = dig_r;
  assign out_free   = !out_valid_r || !out_stall;

  always_comb begin
    ch    = (hv_r[4] & hv_r[5]) ^ (~hv_r[4] & hv_r[6]);
    maj   = (hv_r[0] & hv_r[1]) ^ (hv_r[0] & hv_r[2]) ^ (hv_r[1] & hv_r[2]);
    t1    = hv_r[7] + sha_pkg::big_sigma1(hv_r[4]) + ch
          + sha_pkg::round_const(round_r) + w_r[0];
    t2    = sha_pkg::big_sigma0(hv_r[0]) + maj;
    w_new = sha_pkg::small_sigma1(w_r[14]) + w_r[9]
          + sha_pkg::small_sigma0(w_r[1]) + w_r[0];
  end

  always_comb begin
    state_nxt     = state_r;
    round_nxt     = round_r;
    w_nxt         = w_r;
    hv_nxt        = hv_r;
    dig_nxt       = dig_r;
    out_valid_nxt = out_valid_r && out_stall;
    q_pop         = 1'b0;

    unique case (state_r)
      sha_pkg::ST_LOAD: begin
        if (q_status.not_empty) begin
          q_pop = 1'b1;
          for (int i = 0; i < sha_pkg::BLOCK_WORDS - 1; i++) begin
            w_nxt[i] = w_r[i+1];
          end
          w_nxt[sha_pkg::BLOCK_WORDS-1] = q_status.head.word;
          if (q_status.head.last) begin
            for (int k = 0; k < sha_pkg::DIGEST_N; k++) begin
              hv_nxt[k] = sha_pkg::init_hash(3'(k));
            end
            round_nxt = '0;
            state_nxt = sha_pkg::ST_ROUND;
          end
        end
      end
      sha_pkg::ST_ROUND: begin
        for (int i = 0; i < sha_pkg::BLOCK_WORDS - 1; i++) begin
          w_nxt[i] = w_r[i+1];
        end
        w_nxt[sha_pkg::BLOCK_WORDS-1] = w_new;
        hv_nxt[7] = hv_r[6];
        hv_nxt[6] = hv_r[5];
        hv_nxt[5] = hv_r[4];
        hv_nxt[4] = hv_r[3] + t1;
        hv_nxt[3] = hv_r[2];
        hv_nxt[2] = hv_r[1];
        hv_nxt[1] = hv_r[0];
        hv_nxt[0] = t1 + t2;
        round_nxt = round_r + 1'b1;
        if (round_r == sha_pkg::LAST_ROUND) begin
          state_nxt = sha_pkg::ST_FINISH;
        end
      end
      sha_pkg::ST_FINISH: begin
        if (out_free) begin
          for (int k = 0; k < sha_pkg::DIGEST_N; k++) begin
            dig_nxt[k] = hv_r[k] + sha_pkg::init_hash(3'(k));
          end
          out_valid_nxt = 1'b1;
          state_nxt     = sha_pkg::ST_LOAD;
        end
      end
      default: begin
        state_nxt = sha_pkg::ST_LOAD;
      end
    endcase
  end

  always_comb begin
    status.loading       = (state_r == sha_pkg::ST_LOAD);
    status.rounds_active = (state_r == sha_pkg::ST_ROUND);
    status.finishing     = (state_r == sha_pkg::ST_FINISH);
  end

  always_ff @(posedge clk) begin
    w_r   <= w_nxt;
    hv_r  <= hv_nxt;
    dig_r <= dig_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sha_pkg::ST_LOAD;
      round_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      round_r     <= round_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/sha256_block_compress_unit.sv =====
// Latency: the sixteenth word of a block passes the queue and is loaded; the rounds and finish step follow.
// Throughput: the back end loads, runs the 64 rounds and finishes one block before the next;
// the single shared round datapath, one round per cycle, sets the throughput.
// Reset: synchronous, active low; clears the word counter, queue pointers, state and out_valid.
// The schedule window and working variables are fully rewritten by every block.
`default_nettype none

module sha256_block_compress_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_message_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_digest_word_0,
  output logic [31:0]      out_digest_word_1,
  output logic [31:0]      out_digest_word_2,
  output logic [31:0]      out_digest_word_3,
  output logic [31:0]      out_digest_word_4,
  output logic [31:0]      out_digest_word_5,
  output logic [31:0]      out_digest_word_6,
  output logic [31:0]      out_digest_word_7
);

  // The front end counts words within a block and tags the sixteenth as the
  // last one. Tagged words go into a four-item queue, so the input side keeps
  // accepting words, until the queue is full, while the back end is still busy with a previous block.
  sha_pkg::q_push_t      q_push;
  sha_pkg::q_status_t    q_status;
  sha_pkg::back_status_t back_status;
  logic                  q_pop;
  logic [7:0][31:0]      digest;

  sha_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_message_word (in_message_word),
    .q_status        (q_status),
    .in_stall        (in_stall),
    .q_push          (q_push)
  );

  sha_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_push   (q_push),
    .q_pop    (q_pop),
    .q_status (q_status)
  );

  // The back end shifts words into its schedule window one per cycle while the queue holds words. When the
  // last word of a block arrives it runs the 64 rounds, expanding the schedule
  // in the same window, and then adds the initial hash into the output
  // register. Loading of the next block may start while that result waits.
  sha_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_status   (q_status),
    .out_stall  (out_stall),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_digest (digest),
    .status     (back_status)
  );

  assign out_digest_word_0 = digest[0];
  assign out_digest_word_1 = digest[1];
  assign out_digest_word_2 = digest[2];
  assign out_digest_word_3 = digest[3];
  assign out_digest_word_4 = digest[4];
  assign out_digest_word_5 = digest[5];
  assign out_digest_word_6 = digest[6];
  assign out_digest_word_7 = digest[7];

`ifndef ASSERT_OFF
  // A new result may only be raised from the finishing step.
  a_result_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(back_status.finishing))
    else $error("result raised outside the finishing step");

  // The queue is drained only while the back end is loading words.
  a_pop_only_loading: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> back_status.loading)
    else $error("queue popped while not loading");

  // A full queue is never reported empty.
  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_status.full |-> q_status.not_empty)
    else $error("queue full and empty at once");
`endif

endmodule

`default_nettype wire
